FILE: rtl/core/mca_pkg.sv
// Shared types and constants of the multichannel sample averager.
package mca_pkg;

  localparam int unsigned MaxChannels = 4;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned SumW        = 24;
  localparam int unsigned CodeW       = 12;
  localparam int unsigned TagW        = 4;
  localparam int unsigned MvW         = 13;
  localparam int unsigned DivisorW    = 8;
  localparam int unsigned IterW       = 5;
  localparam int unsigned ScaleShift  = 12;
  localparam int unsigned MidCode     = 2048;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 13;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_CHANNEL_COUNT  = 3'd0,
    REG_AVERAGE_COUNT  = 3'd1,
    REG_OUTPUT_MODE    = 3'd2,
    REG_REF_MILLIVOLTS = 3'd3,
    REG_AMP_GAIN       = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV_AVG,
    ST_MULT,
    ST_SCALE,
    ST_DIV_MV,
    ST_EMIT
  } state_e;

  // Divider launch request
  typedef struct packed {
    logic             start;
    logic [IterW-1:0] iters;
  } div_ctl_t;

endpackage

FILE: rtl/core/mca_div.sv
// Restoring divider, one quotient bit per cycle, shared by averaging and scaling.
module mca_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mca_pkg::div_ctl_t             ctl_i,
  input  logic [mca_pkg::SumW-1:0]      dividend_i,
  input  logic [mca_pkg::DivisorW-1:0]  divisor_i,
  output logic                          done_o,
  output logic [mca_pkg::SumW-1:0]      quotient_o
);

  logic [mca_pkg::IterW-1:0]    cnt_q, cnt_d;
  logic                         done_q, done_d;
  logic [mca_pkg::DivisorW-1:0] rem_q, dvs_q;
  logic [mca_pkg::SumW-1:0]     dq_q;
  logic [mca_pkg::DivisorW:0]   shifted, diff;
  logic                         fits;

  always_comb begin
    shifted = {rem_q, dq_q[mca_pkg::SumW-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = (shifted >= {1'b0, dvs_q});
  end

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      cnt_d = ctl_i.iters;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == mca_pkg::IterW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Shift dividend out at the top, quotient bits in at the bottom
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[mca_pkg::DivisorW-1:0] : shifted[mca_pkg::DivisorW-1:0];
      dq_q  <= {dq_q[mca_pkg::SumW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

FILE: rtl/core/multichannel_sample_averager.sv
// Top level: accumulates interleaved channel samples and emits block averages.
// Sequence: a sample outside a block's last round is read and added into its channel sum;
// a last-round sample is also averaged and, in millivolt mode, scaled, then emitted.
// A new sample is accepted only in the idle state, after the last one is through, output
// stall included; the shared divider does the average in 24 steps and the scale in 12.
// Reset: all sums read as zero through per-entry valid bits; registers take their defaults.
module multichannel_sample_averager #(
  parameter int unsigned MAX_CHANNELS = mca_pkg::MaxChannels
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mca_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mca_pkg::CfgDataW-1:0]  cfg_data_i,
  // sample stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [15:0] tagged_sample
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,  // [3:0] channel_tag,
                                                       // [16:4] millivolts,
                                                       // [32:17] raw_average
  output logic                          m_axis_tlast   // last_of_block
);

  localparam int unsigned PosW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CntW = $clog2(MAX_CHANNELS + 1) + 1;
  localparam int unsigned SumW = mca_pkg::SumW;
  localparam int unsigned ProdW = 27;

  // configuration registers
  logic [2:0]  chan_cnt_q;
  logic [7:0]  avg_cnt_q;
  logic        mode_q;
  logic [12:0] ref_mv_q;
  logic [7:0]  gain_q;

  // sequencing state
  mca_pkg::state_e state_q, state_d;
  logic [PosW-1:0] position_q, position_d;
  logic [7:0]      round_q, round_d;
  logic [MAX_CHANNELS-1:0] valid_q;

  // per-item datapath
  logic [PosW-1:0]             work_pos_q;
  logic [mca_pkg::SampleW-1:0] sample_q;
  logic                        last_ch_q, last_rd_q;
  logic [SumW-1:0]             rd_data_q;
  logic [mca_pkg::SampleW-1:0] word_q;
  logic signed [ProdW-1:0]     prod_q;
  logic [mca_pkg::MvW-1:0]     mv_q;

  // output register
  logic                        out_valid_q;
  logic [mca_pkg::TagW-1:0]    out_tag_q;
  logic [mca_pkg::MvW-1:0]     out_mv_q;
  logic [mca_pkg::SampleW-1:0] out_raw_q;
  logic                        out_last_q;

  logic [SumW-1:0] sum_mem [MAX_CHANNELS];

  logic                        s_accept, out_free, out_load, mem_we;
  logic [CntW-1:0]             eff_chans;
  logic [7:0]                  eff_avg, eff_gain;
  logic                        last_ch, last_rd;
  logic [SumW-1:0]             sum_new;
  logic signed [mca_pkg::MvW-1:0] code_off;
  logic signed [ProdW-1:0]     prod_d, prod_abs;
  logic                        div_done;
  logic [SumW-1:0]             div_quot, div_dividend;
  logic [mca_pkg::DivisorW-1:0] div_divisor;
  mca_pkg::div_ctl_t           div_ctl;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= 3'd1;
      avg_cnt_q  <= 8'd1;
      mode_q     <= 1'b0;
      ref_mv_q   <= 13'd3300;
      gain_q     <= 8'd1;
    end else if (cfg_valid_i) begin
      case (mca_pkg::cfg_idx_e'(cfg_index_i))
        mca_pkg::REG_CHANNEL_COUNT:  chan_cnt_q <= cfg_data_i[2:0];
        mca_pkg::REG_AVERAGE_COUNT:  avg_cnt_q  <= cfg_data_i[7:0];
        mca_pkg::REG_OUTPUT_MODE:    mode_q     <= cfg_data_i[0];
        mca_pkg::REG_REF_MILLIVOLTS: ref_mv_q   <= cfg_data_i;
        mca_pkg::REG_AMP_GAIN:       gain_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- position bookkeeping ----------------
  always_comb begin
    if (chan_cnt_q == '0) begin
      eff_chans = CntW'(1);
    end else if (32'(chan_cnt_q) > MAX_CHANNELS) begin
      eff_chans = CntW'(MAX_CHANNELS);
    end else begin
      eff_chans = CntW'(chan_cnt_q);
    end
    eff_avg  = (avg_cnt_q == '0) ? 8'd1 : avg_cnt_q;
    eff_gain = (gain_q == '0) ? 8'd1 : gain_q;
    last_ch  = ((CntW'(position_q) + CntW'(1)) >= eff_chans);
    last_rd  = (({1'b0, round_q} + 9'd1) >= {1'b0, eff_avg});
  end

  assign s_accept = s_axis_tvalid & s_axis_tready;

  always_comb begin
    position_d = position_q;
    round_d    = round_q;
    if (s_accept) begin
      if (last_ch) begin
        position_d = '0;
        round_d    = last_rd ? 8'd0 : round_q + 8'd1;
      end else begin
        position_d = position_q + 1'b1;
      end
    end
  end

  // ---------------- state machine ----------------
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mca_pkg::ST_IDLE:    if (s_accept) state_d = mca_pkg::ST_READ;
      mca_pkg::ST_READ:    state_d = last_rd_q ? mca_pkg::ST_DIV_AVG : mca_pkg::ST_IDLE;
      mca_pkg::ST_DIV_AVG: if (div_done) state_d = mode_q ? mca_pkg::ST_EMIT : mca_pkg::ST_MULT;
      mca_pkg::ST_MULT:    state_d = mca_pkg::ST_SCALE;
      mca_pkg::ST_SCALE:   state_d = mca_pkg::ST_DIV_MV;
      mca_pkg::ST_DIV_MV:  if (div_done) state_d = mca_pkg::ST_EMIT;
      mca_pkg::ST_EMIT:    if (out_free) state_d = mca_pkg::ST_IDLE;
      default:             state_d = mca_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    div_ctl       = '0;
    div_dividend  = sum_new;
    div_divisor   = eff_avg;
    unique case (state_q)
      mca_pkg::ST_IDLE: s_axis_tready = 1'b1;
      mca_pkg::ST_READ: begin
        mem_we        = 1'b1;
        div_ctl.start = last_rd_q;
        div_ctl.iters = mca_pkg::IterW'(SumW);
      end
      mca_pkg::ST_SCALE: begin
        div_ctl.start = 1'b1;
        div_ctl.iters = mca_pkg::IterW'(mca_pkg::ScaleShift);
        div_dividend  = {prod_abs[23:12], 12'd0};
        div_divisor   = eff_gain;
      end
      mca_pkg::ST_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mca_pkg::ST_IDLE;
      position_q <= '0;
      round_q    <= '0;
    end else begin
      state_q    <= state_d;
      position_q <= position_d;
      round_q    <= round_d;
    end
  end

  // ---------------- sum memory ----------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sum_mem[work_pos_q] <= last_rd_q ? '0 : sum_new;
    end
    if (s_accept) begin
      rd_data_q <= sum_mem[position_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[work_pos_q] <= 1'b1;
    end
  end

  assign sum_new = (valid_q[work_pos_q] ? rd_data_q : '0) + SumW'(sample_q);

  // ---------------- arithmetic ----------------
  assign code_off = $signed({1'b0, word_q[mca_pkg::CodeW-1:0]})
                  - $signed(mca_pkg::MvW'(mca_pkg::MidCode));
  assign prod_d   = ProdW'(code_off) * ProdW'($signed({1'b0, ref_mv_q}));
  assign prod_abs = prod_q[ProdW-1] ? -prod_q : prod_q;

  mca_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      sample_q   <= s_axis_tdata;
      work_pos_q <= position_q;
      last_ch_q  <= last_ch;
      last_rd_q  <= last_rd;
    end
    if (state_q == mca_pkg::ST_DIV_AVG && div_done) begin
      word_q <= div_quot[mca_pkg::SampleW-1:0];
      mv_q   <= '0;
    end
    if (state_q == mca_pkg::ST_MULT) begin
      prod_q <= prod_d;
    end
    // restore the sign on the scaled magnitude
    if (state_q == mca_pkg::ST_DIV_MV && div_done) begin
      mv_q <= prod_q[ProdW-1] ? -mca_pkg::MvW'(div_quot[11:0])
                              :  mca_pkg::MvW'(div_quot[11:0]);
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_tag_q  <= word_q[15:12];
      out_mv_q   <= mv_q;
      out_raw_q  <= word_q;
      out_last_q <= last_ch_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_raw_q, out_mv_q, out_tag_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------- assertions ----------------
  a_div_start_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> (state_q == mca_pkg::ST_READ || state_q == mca_pkg::ST_SCALE))
    else $error("divider launched outside a launch state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == mca_pkg::ST_DIV_AVG || state_q == mca_pkg::ST_DIV_MV))
    else $error("divider finished while nobody waits for it");

  a_tag_matches_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3:0] == m_axis_tdata[32:29]))
    else $error("channel tag differs from the averaged word");

  a_raw_mode_zero_mv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && mode_q) |-> (m_axis_tdata[16:4] == '0))
    else $error("millivolt field set in raw mode");

  a_position_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s_accept) |-> (32'(position_q) < MAX_CHANNELS))
    else $error("channel position beyond the channel array");

endmodule
